>>> rtl/tss_pkg.sv
// Shared constants, types and saturation helpers for the tridiagonal solver.
// Depends on nothing; used by tss_mul, tss_div and the solver core.
package tss_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 6;
    localparam int ADDR_W    = $clog2(MAX_ROWS);
    localparam int DIV_W     = DATA_W + FRAC_BITS;
    localparam int IN_W      = 4 * DATA_W;
    localparam int OUT_W     = 8 * ((DATA_W + IDX_W + 7) / 8);
    localparam int OUT_PAD   = OUT_W - DATA_W - IDX_W;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef logic signed [DATA_W:0]   q_wide_t;

    localparam q_t Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam q_t Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // divider status toward the core
    typedef struct packed {
        logic busy;
        logic done;
        logic ovf;
        q_t   quot;
    } div_stat_t;

    // clamp a one-bit-wider value to the Q range
    function automatic q_t sat_wide(input q_wide_t v);
        if (v[DATA_W] != v[DATA_W-1])
            return v[DATA_W] ? Q_MIN : Q_MAX;
        else
            return q_t'(v[DATA_W-1:0]);
    endfunction

    function automatic logic ovf_wide(input q_wide_t v);
        return v[DATA_W] != v[DATA_W-1];
    endfunction

endpackage

>>> rtl/tss_mul.sv
// Registered fixed-point multiplier: floor(a*b / 2^F), saturated to Q range.
// Depends on tss_pkg. The result is valid in the cycle after the operands.
module tss_mul
(
    input  logic          clk,
    input  tss_pkg::q_t   op_a,
    input  tss_pkg::q_t   op_b,
    output tss_pkg::q_t   prod,
    output logic          ovf
);

    logic signed [2*tss_pkg::DATA_W-1:0] prod_reg;
    logic signed [2*tss_pkg::DATA_W-1:0] shifted;
    logic [2*tss_pkg::DATA_W-tss_pkg::DATA_W:0] hi_bits;

    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // arithmetic shift is the floor for negative products too
    assign shifted = prod_reg >>> tss_pkg::FRAC_BITS;
    assign hi_bits = shifted[2*tss_pkg::DATA_W-1:tss_pkg::DATA_W-1];
    assign ovf     = !((&hi_bits) || (~|hi_bits));
    assign prod    = ovf ? (shifted[2*tss_pkg::DATA_W-1] ? tss_pkg::Q_MIN : tss_pkg::Q_MAX)
                         : tss_pkg::q_t'(shifted[tss_pkg::DATA_W-1:0]);

endmodule

>>> rtl/tss_div.sv
// Radix-2 restoring divider: (num * 2^F) / den, truncated toward zero, saturated.
// Depends on tss_pkg. One quotient bit per cycle, DIV_W quotient bits per divide.
module tss_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tss_pkg::q_t         num,
    input  tss_pkg::q_t         den,
    output tss_pkg::div_stat_t  stat
);

    localparam int DW    = tss_pkg::DATA_W;
    localparam int QW    = tss_pkg::DIV_W;
    localparam int CNT_W = $clog2(QW);
    localparam logic [QW-1:0] POS_LIM = QW'({1'b0, {(DW-1){1'b1}}});
    localparam logic [QW-1:0] NEG_LIM = POS_LIM + QW'(1);

    logic             busy_reg;
    logic             done_reg;
    logic             zero_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [QW-1:0]    dvd_reg;
    logic [DW-1:0]    dsr_reg;
    logic [DW-1:0]    rem_reg;
    logic [QW-1:0]    quo_reg;

    logic [DW-1:0]    num_mag;
    logic [DW-1:0]    den_mag;
    logic [DW:0]      rem_sh;
    logic [DW:0]      trial;
    logic             take;
    logic [DW-1:0]    neg_val;

    assign num_mag = num[DW-1] ? (~num + 1'b1) : num;
    assign den_mag = den[DW-1] ? (~den + 1'b1) : den;
    assign rem_sh  = {rem_reg, dvd_reg[QW-1]};
    assign trial   = rem_sh - {1'b0, dsr_reg};
    assign take    = !trial[DW];
    assign neg_val = ~quo_reg[DW-1:0] + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (den == '0)
                begin
                    // zero divisor: finish at once with a clamped quotient
                    zero_reg <= 1'b1;
                    neg_reg  <= num[DW-1];
                    done_reg <= 1'b1;
                    busy_reg <= 1'b0;
                end
                else
                begin
                    zero_reg <= 1'b0;
                    neg_reg  <= num[DW-1] ^ den[DW-1];
                    dvd_reg  <= {num_mag, {tss_pkg::FRAC_BITS{1'b0}}};
                    dsr_reg  <= den_mag;
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    cnt_reg  <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= take ? trial[DW-1:0] : rem_sh[DW-1:0];
                quo_reg <= {quo_reg[QW-2:0], take};
                dvd_reg <= {dvd_reg[QW-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QW-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        stat.busy = busy_reg;
        stat.done = done_reg;
        if (zero_reg)
        begin
            stat.ovf  = 1'b1;
            stat.quot = neg_reg ? tss_pkg::Q_MIN : tss_pkg::Q_MAX;
        end
        else if (neg_reg)
        begin
            stat.ovf  = quo_reg > NEG_LIM;
            stat.quot = stat.ovf ? tss_pkg::Q_MIN : tss_pkg::q_t'(neg_val);
        end
        else
        begin
            stat.ovf  = quo_reg > POS_LIM;
            stat.quot = stat.ovf ? tss_pkg::Q_MAX : tss_pkg::q_t'(quo_reg[DW-1:0]);
        end
    end

endmodule

>>> rtl/tridiagonal_system_solver_core.sv
// Tridiagonal solver (Thomas algorithm), Q16.16. Uses tss_pkg, tss_mul, tss_div.
// A new row is taken only in idle, after the previous row's forward step. The shared
// radix-2 divider, one bit per cycle, runs twice per row, once on the final row.
// Final row: forward step, then back-substitution (read, multiply, subtract per row),
// then one solution item per read and load, held while the sink stalls, index n to 0.
// Reset (rst_n, async, active low) clears row count, fault flag and handshakes.
module tridiagonal_system_solver_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    // sub_diag [31:0], diag [63:32], super_diag [95:64], rhs [127:96]
    input  logic [tss_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic                        s_axis_tlast,   // last_row
    // solution [31:0], row_index [37:32], zero pad [39:38]
    output logic [tss_pkg::OUT_W-1:0]   m_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic                        m_axis_tlast,   // final_result (index zero)
    output logic [0:0]                  m_axis_tuser    // fault [0]
);

    localparam int DW = tss_pkg::DATA_W;
    localparam int AW = tss_pkg::ADDR_W;

    // Sequencer: forward step per row, back-substitution and emission on the final row.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FW_RD,     // read c'[i-1], d'[i-1]
        ST_FW_MC,     // multiply a*c'[i-1]
        ST_FW_MD,     // m = b - a*c'[i-1]; multiply a*d'[i-1]
        ST_FW_NUM,    // num = d - a*d'[i-1]
        ST_DVC_GO,
        ST_DVC_WAIT,
        ST_DVD_GO,
        ST_DVD_WAIT,  // write c'[i], d'[i]
        ST_BK_RD,     // read c'[i], d'[i]
        ST_BK_MUL,    // multiply c'[i]*x[i+1]
        ST_BK_SUB,    // x[i] = d'[i] - product, written over d'[i]
        ST_EM_RD,     // read x[j]
        ST_EM_LOAD    // load output register
    } state_t;

    state_t          state_reg;
    logic [AW-1:0]   row_count_reg;
    logic [AW-1:0]   idx_reg;
    logic [AW-1:0]   ptr_reg;
    logic            final_reg;
    logic            fault_reg;
    tss_pkg::q_t     a_reg;
    tss_pkg::q_t     b_reg;
    tss_pkg::q_t     c_reg;
    tss_pkg::q_t     d_reg;
    tss_pkg::q_t     m_reg;
    tss_pkg::q_t     num_reg;
    tss_pkg::q_t     c_new_reg;
    tss_pkg::q_t     x_reg;

    logic            out_valid_reg;
    tss_pkg::q_t     out_sol_reg;
    logic [AW-1:0]   out_idx_reg;
    logic            out_last_reg;
    logic            out_fault_reg;

    // c' and d' stores; d' entries become x during back-substitution
    tss_pkg::q_t     sup_mem [tss_pkg::MAX_ROWS];
    tss_pkg::q_t     rhs_mem [tss_pkg::MAX_ROWS];
    tss_pkg::q_t     rd_sup_reg;
    tss_pkg::q_t     rd_rhs_reg;

    logic            rd_en;
    logic            sup_we;
    logic            rhs_we;
    logic [AW-1:0]   rhs_waddr;
    tss_pkg::q_t     rhs_wdata;

    tss_pkg::q_t     mul_a;
    tss_pkg::q_t     mul_b;
    tss_pkg::q_t     mul_p;
    logic            mul_ovf;

    tss_pkg::q_t     sub_lhs;
    tss_pkg::q_wide_t sub_wide;
    tss_pkg::q_t     sub_res;
    logic            sub_ovf;

    logic            div_start;
    tss_pkg::q_t     div_num;
    tss_pkg::div_stat_t div_stat;

    logic            in_take;
    logic            out_free;
    logic            row0_in;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign row0_in       = (row_count_reg == '0);

    // Shared multiplier operands
    always_comb
    begin
        case (state_reg)
            ST_FW_MC:
            begin
                mul_a = a_reg;
                mul_b = rd_sup_reg;
            end
            ST_FW_MD:
            begin
                mul_a = a_reg;
                mul_b = rd_rhs_reg;
            end
            default:
            begin
                mul_a = rd_sup_reg;
                mul_b = x_reg;
            end
        endcase
    end

    tss_mul u_mul
    (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p),
        .ovf  (mul_ovf)
    );

    // Shared subtract-and-saturate after the multiplier
    always_comb
    begin
        case (state_reg)
            ST_FW_MD:  sub_lhs = b_reg;
            ST_FW_NUM: sub_lhs = d_reg;
            default:   sub_lhs = rd_rhs_reg;
        endcase
    end

    assign sub_wide = {sub_lhs[DW-1], sub_lhs} - {mul_p[DW-1], mul_p};
    assign sub_res  = tss_pkg::sat_wide(sub_wide);
    assign sub_ovf  = tss_pkg::ovf_wide(sub_wide);

    // Divider: c'/m first (skipped on the final row), then num/m
    assign div_start = ((state_reg == ST_DVC_GO) && !final_reg) || (state_reg == ST_DVD_GO);
    assign div_num   = (state_reg == ST_DVC_GO) ? c_reg : num_reg;

    tss_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (m_reg),
        .stat  (div_stat)
    );

    // Memory port control. Reads and writes sit in different states, and a
    // read never targets an entry written in the same row step: no forwarding.
    assign rd_en     = (state_reg == ST_FW_RD) || (state_reg == ST_BK_RD)
                    || (state_reg == ST_EM_RD);
    assign sup_we    = (state_reg == ST_DVD_WAIT) && div_stat.done;
    assign rhs_we    = sup_we || (state_reg == ST_BK_SUB);
    assign rhs_waddr = sup_we ? idx_reg : ptr_reg;
    assign rhs_wdata = sup_we ? div_stat.quot : sub_res;

    always_ff @(posedge clk)
    begin
        if (sup_we)
            sup_mem[idx_reg] <= c_new_reg;
        if (rhs_we)
            rhs_mem[rhs_waddr] <= rhs_wdata;
        if (rd_en)
        begin
            rd_sup_reg <= sup_mem[ptr_reg];
            rd_rhs_reg <= rhs_mem[ptr_reg];
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_count_reg <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            final_reg     <= 1'b0;
            fault_reg     <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            m_reg         <= '0;
            num_reg       <= '0;
            c_new_reg     <= '0;
            x_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_sol_reg   <= '0;
            out_idx_reg   <= '0;
            out_last_reg  <= 1'b0;
            out_fault_reg <= 1'b0;
        end
        else
        begin
            // EM_LOAD drives the output valid itself
            if (out_valid_reg && m_axis_tready && (state_reg != ST_EM_LOAD))
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        a_reg     <= tss_pkg::q_t'(s_axis_tdata[DW-1:0]);
                        b_reg     <= tss_pkg::q_t'(s_axis_tdata[2*DW-1:DW]);
                        c_reg     <= tss_pkg::q_t'(s_axis_tdata[3*DW-1:2*DW]);
                        d_reg     <= tss_pkg::q_t'(s_axis_tdata[4*DW-1:3*DW]);
                        final_reg <= s_axis_tlast
                                  || (row_count_reg == AW'(tss_pkg::MAX_ROWS-1));
                        idx_reg   <= row_count_reg;
                        ptr_reg   <= row_count_reg - 1'b1;
                        if (row0_in)
                        begin
                            // first row: divisor is b, numerator is d
                            m_reg     <= tss_pkg::q_t'(s_axis_tdata[2*DW-1:DW]);
                            num_reg   <= tss_pkg::q_t'(s_axis_tdata[4*DW-1:3*DW]);
                            state_reg <= ST_DVC_GO;
                        end
                        else
                        begin
                            state_reg <= ST_FW_RD;
                        end
                    end
                end
                ST_FW_RD:
                begin
                    state_reg <= ST_FW_MC;
                end
                ST_FW_MC:
                begin
                    state_reg <= ST_FW_MD;
                end
                ST_FW_MD:
                begin
                    m_reg     <= sub_res;
                    fault_reg <= fault_reg | mul_ovf | sub_ovf;
                    state_reg <= ST_FW_NUM;
                end
                ST_FW_NUM:
                begin
                    num_reg   <= sub_res;
                    fault_reg <= fault_reg | mul_ovf | sub_ovf;
                    state_reg <= ST_DVC_GO;
                end
                ST_DVC_GO:
                begin
                    if (final_reg)
                    begin
                        c_new_reg <= '0;
                        state_reg <= ST_DVD_GO;
                    end
                    else
                    begin
                        state_reg <= ST_DVC_WAIT;
                    end
                end
                ST_DVC_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        c_new_reg <= div_stat.quot;
                        fault_reg <= fault_reg | div_stat.ovf;
                        state_reg <= ST_DVD_GO;
                    end
                end
                ST_DVD_GO:
                begin
                    state_reg <= ST_DVD_WAIT;
                end
                ST_DVD_WAIT:
                begin
                    if (div_stat.done)
                    begin
                        fault_reg <= fault_reg | div_stat.ovf;
                        x_reg     <= div_stat.quot;
                        if (!final_reg)
                        begin
                            row_count_reg <= idx_reg + 1'b1;
                            state_reg     <= ST_IDLE;
                        end
                        else if (idx_reg == '0)
                        begin
                            ptr_reg   <= '0;
                            state_reg <= ST_EM_RD;
                        end
                        else
                        begin
                            ptr_reg   <= idx_reg - 1'b1;
                            state_reg <= ST_BK_RD;
                        end
                    end
                end
                ST_BK_RD:
                begin
                    state_reg <= ST_BK_MUL;
                end
                ST_BK_MUL:
                begin
                    state_reg <= ST_BK_SUB;
                end
                ST_BK_SUB:
                begin
                    x_reg     <= sub_res;
                    fault_reg <= fault_reg | mul_ovf | sub_ovf;
                    if (ptr_reg == '0)
                    begin
                        // back-substitution done: emit from the top index down
                        ptr_reg   <= idx_reg;
                        state_reg <= ST_EM_RD;
                    end
                    else
                    begin
                        ptr_reg   <= ptr_reg - 1'b1;
                        state_reg <= ST_BK_RD;
                    end
                end
                ST_EM_RD:
                begin
                    state_reg <= ST_EM_LOAD;
                end
                ST_EM_LOAD:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sol_reg   <= rd_rhs_reg;
                        out_idx_reg   <= ptr_reg;
                        out_last_reg  <= (ptr_reg == '0);
                        out_fault_reg <= fault_reg;
                        if (ptr_reg == '0)
                        begin
                            row_count_reg <= '0;
                            state_reg     <= ST_IDLE;
                        end
                        else
                        begin
                            ptr_reg   <= ptr_reg - 1'b1;
                            state_reg <= ST_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {{tss_pkg::OUT_PAD{1'b0}}, tss_pkg::IDX_W'(out_idx_reg), out_sol_reg};
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_fault_reg;

    // divider is never restarted while it works
    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // waiting on c' divide means the divider was started
    a_div_wait_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DVC_WAIT) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    // row counter stays inside the store
    a_row_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= AW'(tss_pkg::MAX_ROWS-1))
        else $error("row count past last row");

    // fault flag is sticky
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(fault_reg))
        else $error("fault flag cleared");

    // no read of an entry in the cycle it is written
    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (rhs_we && rd_en) |-> (rhs_waddr != ptr_reg))
        else $error("read and write of the same store entry");

endmodule
